/* hdl/sps_pkg.sv */
// shared constants for the saddle point stencil scan
package sps_pkg;

    // default build sizes
    localparam int MAX_WIDTH_DEFAULT = 256;
    localparam int VEL_BITS_DEFAULT  = 32;

    // configuration register layout
    localparam int CFG_INDEX_W   = 1;
    localparam int CFG_DATA_W    = 13;
    localparam int GRID_WIDTH_W  = 9;
    localparam int GRID_HEIGHT_W = 13;

    localparam logic [CFG_INDEX_W-1:0] REG_GRID_WIDTH  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_GRID_HEIGHT = 1'b1;

    // reset values and limits of the grid size
    localparam int WIDTH_RESET  = 150;
    localparam int HEIGHT_RESET = 150;
    localparam int HEIGHT_LIMIT = 4096;
    localparam int MIN_DIM      = 3;

    // result field widths
    localparam int COLUMN_W = 8;
    localparam int ROW_W    = 12;
    localparam int COUNT_W  = 20;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

endpackage

/* hdl/sps_row_store.sv */
// line store: one write port, one read port with registered read data
module sps_row_store #(
    parameter int DATA_W = 98,
    parameter int DEPTH  = 256,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem_reg [0:DEPTH-1];
    logic [DATA_W-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* hdl/saddle_point_stencil_scan.sv */
// top level of the saddle point stencil scan
//
// Cells of a velocity field enter in raster order, one transaction per cell, and the
// block sustains one cell per clock while results are taken. Every cell after the first
// row gives one result for the cell directly above it. A taken cell waits in the decision
// stage, whose registers load the result register when the stage advances; cells of the
// first row give none. Both earlier rows live in a single line store of MAX_WIDTH words,
// one word per column holding the prior row's velocities and wall bit and the second row's
// y velocity and wall bit. Its single read port is used once per cell: each cell fetches
// the word of the next column in raster order, which serves as the east neighbour of this
// cell and as the centre of the next one, so the port sets the rate of one cell per clock.
// An output register decouples the result side: while a result waits to be taken, one
// more cell can enter the decision stage, and the input then stalls until the result is
// taken. Grid size registers are written while the block is idle, a rule for the user the
// block does not enforce; writes take effect at once, and the line store needs no clearing.
module saddle_point_stencil_scan
    import sps_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT,
    parameter int VEL_BITS  = VEL_BITS_DEFAULT
) (
    input  logic                       clk,
    input  logic                       rst_n,
    // configuration write channel
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [CFG_INDEX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_data,
    // cell channel
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic signed [VEL_BITS-1:0] velocity_x,
    input  logic signed [VEL_BITS-1:0] velocity_y,
    input  logic                       wall,
    // result channel
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic                       saddle_flag,
    output logic [COLUMN_W-1:0]        cell_column,
    output logic [ROW_W-1:0]           cell_row,
    output logic [COUNT_W-1:0]         saddle_total,
    output logic                       frame_done
);

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int LW     = (COL_W + 1 > GRID_WIDTH_W) ? COL_W + 1 : GRID_WIDTH_W;
    localparam int WORD_W = 3 * VEL_BITS + 2;

    // line store word layout
    localparam int S_WALL  = 0;
    localparam int S_VY_LO = 1;
    localparam int S_VY_HI = VEL_BITS;
    localparam int P_WALL  = VEL_BITS + 1;
    localparam int P_VY_LO = VEL_BITS + 2;
    localparam int P_VY_HI = 2 * VEL_BITS + 1;
    localparam int P_VX_LO = 2 * VEL_BITS + 2;
    localparam int P_VX_HI = 3 * VEL_BITS + 1;

    // configuration registers
    logic [GRID_WIDTH_W-1:0]  grid_width_reg;
    logic [GRID_HEIGHT_W-1:0] grid_height_reg;

    // scan position and running count
    logic [COL_W-1:0]   col_pos_reg, col_pos_next;
    logic [ROW_W-1:0]   row_pos_reg, row_pos_next;
    logic [COUNT_W-1:0] count_reg, count_next;

    // decision stage
    logic                       s1_valid_reg, s1_valid_next;
    logic signed [VEL_BITS-1:0] s1_vx_reg, s1_vy_reg;
    logic                       s1_wall_reg;
    logic [COL_W-1:0]           s1_col_reg;
    logic [ROW_W-1:0]           s1_row_reg;
    logic                       s1_produce_reg, s1_interior_reg, s1_frame_end_reg;
    logic [WORD_W-1:0]          s1_center_reg;

    // west neighbour, the centre word of the previous cell
    logic signed [VEL_BITS-1:0] west_vx_reg;
    logic                       west_wall_reg;

    // output register
    logic                out_valid_reg, out_valid_next;
    logic                out_flag_reg;
    logic [COLUMN_W-1:0] out_column_reg;
    logic [ROW_W-1:0]    out_row_reg;
    logic [COUNT_W-1:0]  out_total_reg;
    logic                out_done_reg;

    logic [LW-1:0]            gw_ext;
    logic [COL_W-1:0]         last_col;
    logic [ROW_W-1:0]         last_row;
    logic                     in_take, s1_adv, out_free, is_last_col, is_last_row;
    logic [WORD_W-1:0]        rd_word, wr_word;
    logic signed [VEL_BITS-1:0] east_vx, south_vy;
    logic                     east_wall, flag;
    logic [COUNT_W-1:0]       count_upd;

    // clamped last column and last row
    always_comb
    begin
        gw_ext = LW'(grid_width_reg);
        if (gw_ext < LW'(MIN_DIM))
        begin
            last_col = COL_W'(MIN_DIM - 1);
        end
        else if (gw_ext > LW'(MAX_WIDTH))
        begin
            last_col = COL_W'(MAX_WIDTH - 1);
        end
        else
        begin
            last_col = COL_W'(gw_ext - LW'(1));
        end

        if (grid_height_reg < GRID_HEIGHT_W'(MIN_DIM))
        begin
            last_row = ROW_W'(MIN_DIM - 1);
        end
        else if (grid_height_reg > GRID_HEIGHT_W'(HEIGHT_LIMIT))
        begin
            last_row = ROW_W'(HEIGHT_LIMIT - 1);
        end
        else
        begin
            last_row = ROW_W'(grid_height_reg - GRID_HEIGHT_W'(1));
        end
    end

    // handshakes
    assign out_free  = !out_valid_reg || out_ready;
    assign s1_adv    = s1_valid_reg && (!s1_produce_reg || out_free);
    assign in_ready  = !s1_valid_reg || s1_adv;
    assign in_take   = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    // scan position advance
    always_comb
    begin
        is_last_col  = col_pos_reg >= last_col;
        is_last_row  = row_pos_reg >= last_row;
        col_pos_next = col_pos_reg;
        row_pos_next = row_pos_reg;
        if (in_take)
        begin
            if (is_last_col)
            begin
                col_pos_next = '0;
                row_pos_next = is_last_row ? '0 : row_pos_reg + ROW_W'(1);
            end
            else
            begin
                col_pos_next = col_pos_reg + COL_W'(1);
            end
        end
    end

    // line store, read ahead at the next scan column
    sps_row_store #(
        .DATA_W (WORD_W),
        .DEPTH  (MAX_WIDTH),
        .ADDR_W (COL_W)
    ) u_row_store (
        .clk     (clk),
        .wr_en   (s1_adv),
        .wr_addr (s1_col_reg),
        .wr_data (wr_word),
        .rd_en   (in_take),
        .rd_addr (col_pos_next),
        .rd_data (rd_word)
    );

    // new word: arriving cell becomes the prior row, old prior row moves down
    assign wr_word = {s1_vx_reg, s1_vy_reg, s1_wall_reg,
                      s1_center_reg[P_VY_HI:P_VY_LO], s1_center_reg[P_WALL]};

    // saddle decision on the buffered neighbourhood
    always_comb
    begin
        east_vx   = $signed(rd_word[P_VX_HI:P_VX_LO]);
        east_wall = rd_word[P_WALL];
        south_vy  = $signed(s1_center_reg[S_VY_HI:S_VY_LO]);
        flag = s1_interior_reg && !s1_center_reg[P_WALL] && !s1_wall_reg
               && !s1_center_reg[S_WALL] && !east_wall && !west_wall_reg
               && (((east_vx > west_vx_reg) && (s1_vy_reg < south_vy))
                   || ((east_vx < west_vx_reg) && (s1_vy_reg > south_vy)));
        count_upd = (flag && (count_reg != COUNT_MAX)) ? count_reg + COUNT_W'(1)
                                                       : count_reg;
        count_next = count_reg;
        if (s1_adv)
        begin
            count_next = s1_frame_end_reg ? '0 : count_upd;
        end
    end

    // stage and output valid
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_take)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (s1_adv && s1_produce_reg)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg  <= GRID_WIDTH_W'(WIDTH_RESET);
            grid_height_reg <= GRID_HEIGHT_W'(HEIGHT_RESET);
            col_pos_reg     <= '0;
            row_pos_reg     <= '0;
            count_reg       <= '0;
            s1_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            west_vx_reg     <= '0;
            west_wall_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_GRID_WIDTH:  grid_width_reg  <= cfg_data[GRID_WIDTH_W-1:0];
                    REG_GRID_HEIGHT: grid_height_reg <= cfg_data[GRID_HEIGHT_W-1:0];
                endcase
            end
            col_pos_reg   <= col_pos_next;
            row_pos_reg   <= row_pos_next;
            count_reg     <= count_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (s1_adv)
            begin
                west_vx_reg   <= $signed(s1_center_reg[P_VX_HI:P_VX_LO]);
                west_wall_reg <= s1_center_reg[P_WALL];
            end
        end
    end

    // cell capture into the decision stage
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_vx_reg        <= velocity_x;
            s1_vy_reg        <= velocity_y;
            s1_wall_reg      <= wall;
            s1_col_reg       <= col_pos_reg;
            s1_row_reg       <= row_pos_reg - ROW_W'(1);
            s1_produce_reg   <= row_pos_reg != '0;
            s1_interior_reg  <= (col_pos_reg != '0) && (col_pos_reg < last_col)
                                && (row_pos_reg >= ROW_W'(2)) && (row_pos_reg <= last_row);
            s1_frame_end_reg <= is_last_col && is_last_row;
            s1_center_reg    <= rd_word;
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (s1_adv && s1_produce_reg)
        begin
            out_flag_reg   <= flag;
            out_column_reg <= COLUMN_W'(s1_col_reg);
            out_row_reg    <= s1_row_reg;
            out_total_reg  <= count_upd;
            out_done_reg   <= s1_frame_end_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign saddle_flag  = out_flag_reg;
    assign cell_column  = out_column_reg;
    assign cell_row     = out_row_reg;
    assign saddle_total = out_total_reg;
    assign frame_done   = out_done_reg;

endmodule

/* hdl/sps_checker.sv */
// port level checks for the saddle point stencil scan, bound to the top level
module sps_checker
    import sps_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                out_valid,
    input logic                out_ready,
    input logic                saddle_flag,
    input logic [COLUMN_W-1:0] cell_column,
    input logic [ROW_W-1:0]    cell_row,
    input logic [COUNT_W-1:0]  saddle_total,
    input logic                frame_done
);

    // a stalled result transaction holds its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(saddle_flag)
            && $stable(cell_column) && $stable(cell_row)
            && $stable(saddle_total) && $stable(frame_done))
        else $error("result changed while stalled");

    // a flagged cell is always counted
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && saddle_flag |-> saddle_total != '0)
        else $error("saddle flagged with zero total");

    // cells on the first row or the first column are never flagged
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && saddle_flag |-> cell_row != '0 && cell_column != '0)
        else $error("saddle flagged on the border");

    // the closing cell of a frame is never flagged
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_done |-> !saddle_flag)
        else $error("saddle flagged on the closing cell");

endmodule

bind saddle_point_stencil_scan sps_checker u_sps_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .saddle_flag  (saddle_flag),
    .cell_column  (cell_column),
    .cell_row     (cell_row),
    .saddle_total (saddle_total),
    .frame_done   (frame_done)
);

/* tb/testbench.sv */
// self-checking testbench for the saddle point stencil scan with its own stencil predictor
`timescale 1ns / 1ps

module testbench;
    import sps_pkg::*;

    localparam int MAX_W        = MAX_WIDTH_DEFAULT;
    localparam int VEL_W        = VEL_BITS_DEFAULT;
    localparam int TARGET_CELLS = 1250;
    localparam int DRAIN_CYCLES = 8;
    localparam int LONG_HOLD    = 120;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int CFG_PAD_W    = CFG_DATA_W - GRID_WIDTH_W;

    localparam logic signed [VEL_W-1:0] VEL_MIN = {1'b1, {(VEL_W-1){1'b0}}};
    localparam logic signed [VEL_W-1:0] VEL_MAX = {1'b0, {(VEL_W-1){1'b1}}};

    typedef struct packed {
        logic                flag;
        logic [COLUMN_W-1:0] column;
        logic [ROW_W-1:0]    row;
        logic [COUNT_W-1:0]  total;
        logic                done;
    } centre_result_t;

    logic                    clk;
    logic                    rst_n;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CFG_INDEX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0]   cfg_data;
    logic                    in_valid;
    logic                    in_ready;
    logic signed [VEL_W-1:0] velocity_x;
    logic signed [VEL_W-1:0] velocity_y;
    logic                    wall;
    logic                    out_valid;
    logic                    out_ready;
    logic                    saddle_flag;
    logic [COLUMN_W-1:0]     cell_column;
    logic [ROW_W-1:0]        cell_row;
    logic [COUNT_W-1:0]      saddle_total;
    logic                    frame_done;

    // predictor state: row of the centres, row above it, west neighbour, raster position
    logic signed [VEL_W-1:0]  recent_vx [MAX_W];
    logic signed [VEL_W-1:0]  recent_vy [MAX_W];
    logic                     recent_wall [MAX_W];
    logic signed [VEL_W-1:0]  older_vy [MAX_W];
    logic                     older_wall [MAX_W];
    logic signed [VEL_W-1:0]  west_vx_hold;
    logic                     west_wall_hold;
    int unsigned              scan_column;
    int unsigned              scan_row;
    logic [COUNT_W-1:0]       saddle_tally;
    logic [GRID_WIDTH_W-1:0]  width_word;
    logic [GRID_HEIGHT_W-1:0] height_word;
    centre_result_t           awaited_results [$];

    // bookkeeping
    int unsigned failures;
    int unsigned cells_sent;
    int unsigned results_seen;
    int unsigned saddles_seen;
    int unsigned frames_closed;
    int unsigned cycle_count;
    int unsigned hold_requests;
    bit          sender_flat;
    int unsigned tx_stretch;
    bit          tx_gappy;

    saddle_point_stencil_scan #(
        .MAX_WIDTH (MAX_W),
        .VEL_BITS  (VEL_W)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .velocity_x   (velocity_x),
        .velocity_y   (velocity_y),
        .wall         (wall),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .saddle_flag  (saddle_flag),
        .cell_column  (cell_column),
        .cell_row     (cell_row),
        .saddle_total (saddle_total),
        .frame_done   (frame_done)
    );

    // 12 ns clock
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: run stopped after %0d cycles, %0d results still awaited",
                     $time, CYCLE_LIMIT, awaited_results.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic int unsigned clamp_dim(int unsigned value, int unsigned upper);
        if (value < MIN_DIM)
            return MIN_DIM;
        if (value > upper)
            return upper;
        return value;
    endfunction

    // stretches with random idle cycles and stretches with none, picked at random
    function automatic int unsigned draw_wait(inout int unsigned stretch_left, inout bit gappy);
        if (stretch_left == 0)
        begin
            stretch_left = $urandom_range(4, 40);
            gappy = $urandom_range(0, 2) != 0;
        end
        stretch_left--;
        return gappy ? $urandom_range(0, 17) : 0;
    endfunction

    function automatic logic signed [VEL_W-1:0] random_velocity();
        int offset;
        logic signed [VEL_W-1:0] v;
        case ($urandom_range(0, 4))
            0, 1:
            begin
                offset = $urandom_range(0, 6);
                v = offset - 3;
            end
            2, 3:
                v = $urandom();
            default:
                case ($urandom_range(0, 4))
                    0: v = VEL_MIN;
                    1: v = VEL_MAX;
                    2: v = '0;
                    3: v = -1;
                    default: v = 1;
                endcase
        endcase
        return v;
    endfunction

    // stencil decision for one arriving cell, then line store and position update
    function automatic void track_cell(logic signed [VEL_W-1:0] vx,
                                       logic signed [VEL_W-1:0] vy, logic wl);
        int unsigned    cols;
        int unsigned    rows;
        int unsigned    x;
        int unsigned    y;
        int unsigned    east;
        bit             at_last_col;
        bit             at_last_row;
        bit             flagged;
        bit             clear;
        centre_result_t res;
        cols = clamp_dim(32'(width_word), MAX_W);
        rows = clamp_dim(32'(height_word), HEIGHT_LIMIT);
        x = scan_column;
        y = scan_row;
        at_last_col = x >= cols - 1;
        at_last_row = y >= rows - 1;
        if (y >= 1)
        begin
            flagged = 1'b0;
            // interior centre only: the stores are not looked at for border centres
            if (x >= 1 && x + 1 < cols && y >= 2 && y + 1 <= rows)
            begin
                east = x + 1;
                clear = !recent_wall[x] && !wl && !older_wall[x] &&
                        !recent_wall[east] && !west_wall_hold;
                // opposite signs of east-west and north-south differences, no subtraction
                if (clear)
                    flagged = (recent_vx[east] > west_vx_hold && vy < older_vy[x]) ||
                              (recent_vx[east] < west_vx_hold && vy > older_vy[x]);
            end
            if (flagged && saddle_tally != COUNT_MAX)
                saddle_tally++;
            res.flag   = flagged;
            res.column = x[COLUMN_W-1:0];
            res.row    = ROW_W'(y - 1);
            res.total  = saddle_tally;
            res.done   = at_last_col && at_last_row;
            awaited_results.push_back(res);
        end
        west_vx_hold   = recent_vx[x];
        west_wall_hold = recent_wall[x];
        older_vy[x]    = recent_vy[x];
        older_wall[x]  = recent_wall[x];
        recent_vx[x]   = vx;
        recent_vy[x]   = vy;
        recent_wall[x] = wl;
        if (at_last_col)
        begin
            scan_column = 0;
            if (at_last_row)
            begin
                scan_row = 0;
                saddle_tally = '0;
            end
            else
            begin
                scan_row = y + 1;
            end
        end
        else
        begin
            scan_column = x + 1;
        end
    endfunction

    // cells still needed to close the frame under the given register words
    function automatic int unsigned cells_left(logic [CFG_DATA_W-1:0] wdata,
                                               logic [CFG_DATA_W-1:0] hdata);
        int unsigned cols;
        int unsigned rows;
        int unsigned rest;
        cols = clamp_dim(32'(wdata[GRID_WIDTH_W-1:0]), MAX_W);
        rows = clamp_dim(32'(hdata[GRID_HEIGHT_W-1:0]), HEIGHT_LIMIT);
        rest = (scan_column >= cols - 1) ? 1 : cols - scan_column;
        if (scan_row < rows - 1)
            rest += (rows - 1 - scan_row) * cols;
        return rest;
    endfunction

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            failures++;
        end
    endtask

    task automatic check_result();
        centre_result_t want;
        results_seen++;
        if (awaited_results.size() == 0)
        begin
            $display("%0t: result for column %0d row %0d with no cell to account for it",
                     $time, cell_column, cell_row);
            failures++;
        end
        else
        begin
            want = awaited_results.pop_front();
            compare_field("saddle_flag", 32'(want.flag), 32'(saddle_flag));
            compare_field("cell_column", 32'(want.column), 32'(cell_column));
            compare_field("cell_row", 32'(want.row), 32'(cell_row));
            compare_field("saddle_total", 32'(want.total), 32'(saddle_total));
            compare_field("frame_done", 32'(want.done), 32'(frame_done));
            if (want.flag)
                saddles_seen++;
            if (want.done)
                frames_closed++;
        end
    endtask

    // watch every transaction on the three channels
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                check_result();
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_GRID_WIDTH)
                    width_word = cfg_data[GRID_WIDTH_W-1:0];
                else
                    height_word = cfg_data[GRID_HEIGHT_W-1:0];
            end
            if (in_valid && in_ready)
                track_cell(velocity_x, velocity_y, wall);
        end
    end

    // result side: random stalls, and a long hold on request
    initial
    begin : result_sink
        int unsigned stall;
        int unsigned served;
        int unsigned rx_stretch;
        bit          rx_gappy;
        out_ready = 1'b0;
        served = 0;
        rx_stretch = 0;
        rx_gappy = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_requests != served)
            begin
                served = hold_requests;
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            stall = draw_wait(rx_stretch, rx_gappy);
            if (stall != 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
        end
    end

    // one cell transaction; valid stays high into the next cell when there is no gap
    task automatic send_cell(input logic signed [VEL_W-1:0] vx,
                             input logic signed [VEL_W-1:0] vy, input logic wl);
        int unsigned gap;
        gap = sender_flat ? 0 : draw_wait(tx_stretch, tx_gappy);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        velocity_x <= vx;
        velocity_y <= vy;
        wall       <= wl;
        do
            @(posedge clk);
        while (!in_ready);
        cells_sent++;
    endtask

    task automatic send_random_cells(input int unsigned count);
        repeat (count)
            send_cell(random_velocity(), random_velocity(), $urandom_range(0, 9) == 0);
    endtask

    // wait until every result is in and the pipeline has run dry
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // both grid registers, back to back with valid held high
    task automatic configure_grid(input logic [CFG_DATA_W-1:0] wdata,
                                  input logic [CFG_DATA_W-1:0] hdata);
        cfg_valid <= 1'b1;
        cfg_index <= REG_GRID_WIDTH;
        cfg_data  <= wdata;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_index <= REG_GRID_HEIGHT;
        cfg_data  <= hdata;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_to_frame_end(input logic [CFG_DATA_W-1:0] wdata,
                                    input logic [CFG_DATA_W-1:0] hdata,
                                    input int unsigned extra_frames);
        int unsigned count;
        settle();
        count = cells_left(wdata, hdata) + extra_frames *
                clamp_dim(32'(wdata[GRID_WIDTH_W-1:0]), MAX_W) *
                clamp_dim(32'(hdata[GRID_HEIGHT_W-1:0]), HEIGHT_LIMIT);
        configure_grid(wdata, hdata);
        send_random_cells(count);
    endtask

    // sizes from reset, then shrunk mid-frame to close it quickly
    task automatic test_reset_dimensions();
        send_random_cells(WIDTH_RESET + 2);
        run_to_frame_end(13'd4, 13'd3, 0);
    endtask

    // one narrow frame: extreme differences, opposite and equal signs, zero differences, a wall
    task automatic test_directed_stencil();
        logic signed [VEL_W-1:0] west_seq [8];
        logic signed [VEL_W-1:0] east_seq [8];
        logic signed [VEL_W-1:0] centre_vy_seq [8];
        west_seq      = '{0, VEL_MIN, VEL_MAX, 5, 0, 3, -9, 2};
        east_seq      = '{-1, VEL_MAX, VEL_MIN, 5, 1, 7, 4, VEL_MAX};
        centre_vy_seq = '{VEL_MAX, 0, VEL_MIN, VEL_MAX, -1, VEL_MAX, 5, VEL_MIN};
        settle();
        configure_grid(13'd3, 13'd8);
        for (int r = 0; r < 8; r++)
        begin
            send_cell(west_seq[r], random_velocity(), r == 6);
            send_cell(r[0] ? VEL_MAX : VEL_MIN, centre_vy_seq[r], 1'b0);
            send_cell(east_seq[r], random_velocity(), 1'b0);
        end
    endtask

    // register words below the minimum, some with unused upper bits set
    task automatic test_clamped_minimum();
        run_to_frame_end(13'd0, 13'd1, 0);
        run_to_frame_end(13'h0E01, 13'd0, 0);
        run_to_frame_end(13'd2, 13'd2, 0);
    endtask

    // all-ones words: widest rows and tallest height, then the height cut mid-frame
    task automatic test_widest_field();
        settle();
        configure_grid(13'h1FFF, 13'h1FFF);
        send_random_cells(2 * MAX_W + 3);
        run_to_frame_end(13'h1FFF, 13'd3, 0);
    endtask

    // narrower rows and more of them from partway through a frame
    task automatic test_change_within_frame();
        settle();
        configure_grid(13'd10, 13'd6);
        send_random_cells(23);
        run_to_frame_end(13'd5, 13'd9, 0);
    endtask

    // long hold on results while cells keep coming
    task automatic test_result_backpressure();
        settle();
        configure_grid(13'd8, 13'd6);
        sender_flat = 1'b1;
        hold_requests <= hold_requests + 1;
        send_random_cells(48);
        sender_flat = 1'b0;
    endtask

    // whole frames of random size and content, sometimes two in a row
    task automatic test_random_frames();
        int unsigned               base;
        logic [CFG_DATA_W-1:0]     wdata;
        logic [CFG_DATA_W-1:0]     hdata;
        while (cells_sent < TARGET_CELLS)
        begin
            case ($urandom_range(0, 9))
                0: base = $urandom_range(0, 2);
                1: base = $urandom_range(13, 40);
                default: base = $urandom_range(3, 12);
            endcase
            wdata = CFG_DATA_W'(base);
            wdata[CFG_DATA_W-1:GRID_WIDTH_W] = CFG_PAD_W'($urandom_range(0, 15));
            if ($urandom_range(0, 7) == 0)
                hdata = CFG_DATA_W'($urandom_range(0, 2));
            else
                hdata = CFG_DATA_W'($urandom_range(3, 8));
            run_to_frame_end(wdata, hdata, $urandom_range(0, 1));
        end
    endtask

    initial
    begin : stimulus
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_GRID_WIDTH;
        cfg_data = '0;
        in_valid = 1'b0;
        velocity_x = '0;
        velocity_y = '0;
        wall = 1'b0;
        width_word = GRID_WIDTH_W'(WIDTH_RESET);
        height_word = GRID_HEIGHT_W'(HEIGHT_RESET);
        west_vx_hold = '0;
        west_wall_hold = 1'b0;
        scan_column = 0;
        scan_row = 0;
        saddle_tally = '0;
        failures = 0;
        cells_sent = 0;
        results_seen = 0;
        saddles_seen = 0;
        frames_closed = 0;
        cycle_count = 0;
        hold_requests = 0;
        sender_flat = 1'b0;
        tx_stretch = 0;
        tx_gappy = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_dimensions();
        test_directed_stencil();
        test_clamped_minimum();
        test_widest_field();
        test_change_within_frame();
        test_result_backpressure();
        test_random_frames();
        settle();

        $display("%0d cells streamed, %0d centres checked, %0d saddles, %0d frames closed",
                 cells_sent, results_seen, saddles_seen, frames_closed);
        $display("grids from the clamped 3x3 up to 256 columns, mid-frame resizing, long hold");
        if (failures == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
